// ===== rtl/ckrp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckrp_pkg
// Shared types and constants for the color-key sparse row packer.
// ----------------------------------------------------------------------------
package ckrp_pkg;
	localparam int MAX_WIDTH = 124;
	localparam int CW = 7;
	localparam int AW = 7;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_KEY    = 2'd2;
	localparam logic [1:0] REG_CAP    = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HDR,
		ST_LIT,
		ST_TAIL,
		ST_NONE
	} state_t;

	// word being built by the datapath
	typedef enum logic [1:0] {
		W_HDR,
		W_LIT,
		W_ZERO,
		W_SKIP
	} wsel_t;

	typedef struct packed {
		logic   take;       // latch pixel
		logic   put;        // produce result
		wsel_t  wsel;
		logic   lit_step;   // advance literal pointer
		logic   clr_run;    // clear skip and run
		logic   bump_skip;  // skip += 1
		logic   is_last;
		logic   finish;     // end-of-pixel position update
	} cmd_t;

	typedef struct packed {
		logic is_key;
		logic run_nz;
		logic row_end;
		logic lit_more;     // more literal words remain after this one
		logic out_busy;     // output register full and stalled
	} sts_t;
endpackage

// ===== rtl/ckrp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckrp_ctrl
// Sequencer: walks header, literal and tail words for each pixel.
// ----------------------------------------------------------------------------
module ckrp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  ckrp_pkg::sts_t sts,
	output ckrp_pkg::cmd_t cmd
);
	import ckrp_pkg::*;

	state_t state_q, state_n;
	logic   key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			key_q   <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.take) key_q <= sts.is_key;
		end
	end

	// Pixel is latched in IDLE; decision uses run/row state of the latch.
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_n = ST_NONE;
			ST_NONE: begin
				if (!sts.out_busy) begin
					if (key_q && sts.run_nz) state_n = ST_HDR;
					else if (!key_q && sts.row_end) state_n = ST_HDR;
					else if (key_q && sts.row_end) state_n = ST_TAIL;
					else state_n = ST_TAIL;
				end
			end
			ST_HDR: if (!sts.out_busy) state_n = sts.run_nz ? ST_LIT : ST_TAIL;
			ST_LIT: if (!sts.out_busy && !sts.lit_more) begin
				state_n = (key_q && !sts.row_end) ? ST_IDLE : ST_TAIL;
			end
			ST_TAIL: if (!sts.out_busy) state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.wsel = W_HDR;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.take = in_valid;
			end
			ST_NONE: ;
			ST_HDR: if (!sts.out_busy) begin
				cmd.put = 1'b1;
				cmd.wsel = W_HDR;
			end
			ST_LIT: if (!sts.out_busy) begin
				cmd.put = 1'b1;
				cmd.wsel = W_LIT;
				cmd.lit_step = 1'b1;
				if (!sts.lit_more) begin
					cmd.clr_run = 1'b1;
					// key mid-row: the last literal closes the request
					if (key_q && !sts.row_end) begin
						cmd.bump_skip = 1'b1;
						cmd.is_last = 1'b1;
						cmd.finish = 1'b1;
					end
				end
			end
			ST_TAIL: if (!sts.out_busy) begin
				// key: bump skip, emit skip word on row end; opaque: zero word on row end
				cmd.bump_skip = key_q;
				cmd.put = sts.row_end;
				cmd.wsel = key_q ? W_SKIP : W_ZERO;
				cmd.is_last = 1'b1;
				cmd.finish = 1'b1;
			end
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |=> state_q == ST_NONE)
		else $error("take did not start sequence");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> state_q == ST_IDLE)
		else $error("finish did not return to idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.lit_step |-> !cmd.take)
		else $error("conflicting commands");
endmodule

// ===== rtl/ckrp_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckrp_dp
// Datapath: config, position counters, run buffer, capacity and output reg.
// ----------------------------------------------------------------------------
module ckrp_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [15:0]   pixel,
	input  logic          cfg_valid,
	input  logic [1:0]    cfg_index,
	input  logic [23:0]   cfg_data,
	input  ckrp_pkg::cmd_t cmd,
	output ckrp_pkg::sts_t sts,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [31:0]   out_word,
	output logic          word_valid,
	output logic          last,
	output logic          frame_done,
	output logic          status,
	output logic [23:0]   frame_words
);
	import ckrp_pkg::*;

	logic [6:0]  width_q;
	logic [15:0] height_q, key_q, row_q;
	logic [23:0] cap_q, used_q;
	logic [CW-1:0] col_q, skip_q, run_q, ptr_q;
	logic        ovf_q;
	logic [15:0] mem [MAX_WIDTH];
	logic [15:0] rd_lo_q, rd_hi_q;
	logic [CW-1:0] run_eff;

	logic [6:0]  w_eff;
	logic [15:0] h_eff;
	logic        row_end, frame_end, is_key;

	always_comb begin
		w_eff = width_q;
		if (w_eff == 7'd0) w_eff = 7'd1;
		if (w_eff > 7'(MAX_WIDTH)) w_eff = 7'(MAX_WIDTH);
		h_eff = (height_q == 16'd0) ? 16'd1 : height_q;
	end
	assign row_end   = ({1'b0, col_q} + 8'd1) >= {1'b0, w_eff};
	assign frame_end = row_end && (({1'b0, row_q} + 17'd1) >= {1'b0, h_eff});
	assign is_key    = (pixel == key_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 7'(MAX_WIDTH);
			height_q <= 16'd1;
			key_q    <= 16'd0;
			cap_q    <= 24'hFFFFFF;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[6:0];
				REG_HEIGHT: height_q <= cfg_data[15:0];
				REG_KEY:    key_q    <= cfg_data[15:0];
				REG_CAP:    cap_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Buffer the opaque pixel at take; run_q then counts it, so later states see it.
	always_ff @(posedge clk) begin
		if (cmd.take && !is_key && run_q < CW'(MAX_WIDTH)) mem[run_q[AW-1:0]] <= pixel;
	end

	// Read pair registered; ptr advances one pair per literal word.
	logic [CW-1:0] rd_a, rd_b;
	assign rd_a = cmd.lit_step ? ptr_q + CW'(2) : ptr_q;
	assign rd_b = rd_a + CW'(1);
	always_ff @(posedge clk) begin
		rd_lo_q <= mem[(rd_a < CW'(MAX_WIDTH)) ? rd_a[AW-1:0] : AW'(0)];
		rd_hi_q <= mem[(rd_b < CW'(MAX_WIDTH)) ? rd_b[AW-1:0] : AW'(0)];
	end

	// Opaque pixel joins the run at take, so a key flush sees the old run only.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0; row_q <= '0; skip_q <= '0; run_q <= '0; ptr_q <= '0;
			used_q <= '0; ovf_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if (cmd.take) begin
				ptr_q <= '0;
				if (!is_key && run_q < CW'(MAX_WIDTH)) run_q <= run_q + CW'(1);
			end
			if (cmd.lit_step) ptr_q <= ptr_q + CW'(2);
			if (cmd.put) begin
				if (!ovf_q && used_q < cap_q) used_q <= used_q + 24'd1;
				else ovf_q <= 1'b1;
			end
			if (cmd.clr_run) begin
				skip_q <= '0; run_q <= '0;
			end
			if (cmd.is_last) begin
				out_valid <= 1'b1;
				// a flush in the same cycle restarts the skip count from zero
				if (cmd.bump_skip && !row_end)
					skip_q <= (cmd.clr_run ? CW'(0) : skip_q) + CW'(1);
			end else if (cmd.put) out_valid <= 1'b1;
			if (cmd.finish) begin
				if (row_end) begin
					col_q <= '0; skip_q <= '0; run_q <= '0;
					if (frame_end) begin
						row_q <= '0; used_q <= '0; ovf_q <= 1'b0;
					end else row_q <= row_q + 16'd1;
				end else col_q <= col_q + CW'(1);
			end
		end
	end
	assign run_eff = run_q;

	// Output register
	logic        ok;
	logic        ovf_n;
	logic [23:0] used_n;
	logic [31:0] word_n;
	logic [CW-1:0] skip_w;
	assign ok = cmd.put && !ovf_q && used_q < cap_q;
	assign ovf_n = ovf_q || (cmd.put && !ok);
	assign used_n = used_q + (ok ? 24'd1 : 24'd0);
	assign skip_w = skip_q + CW'(1);
	always_comb begin
		case (cmd.wsel)
			W_HDR:  word_n = {9'd0, run_eff, 9'd0, skip_q};
			W_LIT:  word_n = {((ptr_q + CW'(1)) < run_eff) ? rd_hi_q : 16'd0, rd_lo_q};
			W_SKIP: word_n = {25'd0, skip_w};
			default: word_n = 32'd0;
		endcase
	end
	always_ff @(posedge clk) begin
		if (cmd.put || cmd.is_last) begin
			out_word    <= ok ? word_n : 32'd0;
			word_valid  <= ok;
			last        <= cmd.is_last;
			frame_done  <= cmd.is_last && frame_end;
			status      <= ovf_n;
			frame_words <= (cmd.is_last && frame_end && !ovf_n) ? used_n : 24'd0;
		end
	end

	assign sts.is_key   = is_key;
	assign sts.run_nz   = (run_q != '0);
	assign sts.row_end  = row_end;
	assign sts.lit_more = (ptr_q + CW'(2)) < run_eff;
	assign sts.out_busy = out_valid && out_stall;

	assert property (@(posedge clk) disable iff (!arst_n)
		run_q <= CW'(MAX_WIDTH)) else $error("run overran buffer");
	assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> !ok) else $error("word accepted after overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.put || cmd.is_last) |-> !sts.out_busy) else $error("overwrote held word");
endmodule

// ===== rtl/color_key_sparse_row_packer_core.sv =====
`timescale 1ns / 1ps
// Sequence: a taken pixel goes through the NONE decision state, then HDR and LIT
//   words when a run flushes, then TAIL unless a key pixel flushed the run mid-row;
//   no new pixel is taken until the sequence returns to IDLE; one word per cycle
//   while the held output word is not stalled.
// Reset: arst_n clears counters and loads width 124, height 1, key 0, full
//   capacity; the run buffer is not cleared and is only read after writes.
// ----------------------------------------------------------------------------
// color_key_sparse_row_packer_core
// Top level: joins sequencer and datapath.
// ----------------------------------------------------------------------------
module color_key_sparse_row_packer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] pixel,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] out_word,
	output logic        word_valid,
	output logic        last,
	output logic        frame_done,
	output logic        status,
	output logic [23:0] frame_words
);
	import ckrp_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// configuration is always taken
	assign cfg_ready = 1'b1;

	ckrp_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .sts, .cmd
	);

	ckrp_dp u_dp (
		.clk, .arst_n, .pixel,
		.cfg_valid, .cfg_index, .cfg_data,
		.cmd, .sts,
		.out_valid, .out_stall, .out_word, .word_valid,
		.last, .frame_done, .status, .frame_words
	);
endmodule
